@@ hw/rtl/thick_line_rasterizer_top_macros.svh @@
// Assertion macros shared by the thick line rasterizer RTL.
// Every macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef THICK_LINE_RASTERIZER_TOP_MACROS_SVH
`define THICK_LINE_RASTERIZER_TOP_MACROS_SVH

// A property checked at every clock edge outside reset.
`define TLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition in one cycle that requires an expression in the next one.
`define TLR_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ hw/rtl/tlr_pkg.sv @@
// Package of the thick line rasterizer: operation and register codes,
// reset values of the window registers and the core status struct. No dependencies.
package tlr_pkg;

  localparam int CFG_W = 13;
  localparam int ADDR_W = 24;
  localparam int COLOR_W = 32;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic REG_WINDOW_WIDTH  = 1'b0;
  localparam logic REG_WINDOW_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIN_W_RESET = 13'd640;
  localparam logic [CFG_W-1:0] WIN_H_RESET = 13'd480;

  // Status of the line walker for the current step.
  typedef struct packed {
    logic busy;  // a line is in progress, so a step produces a pixel
    logic last;  // this pixel closes the final stamp of the end point
  } core_flags_t;

endpackage

@@ hw/rtl/tlr_core.sv @@
// Line walker of the thick line rasterizer: Bresenham state and brush offsets.
// Depends on tlr_pkg.
module tlr_core import tlr_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int THICK_BITS = 8,
  localparam int PW = ((COORD_BITS > THICK_BITS) ? COORD_BITS : THICK_BITS) + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         op_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic        [THICK_BITS-1:0] thickness_i,
  input  logic        [COLOR_W-1:0]    color_i,
  output logic signed [PW-1:0]         px_o,
  output logic signed [PW-1:0]         py_o,
  output logic        [COLOR_W-1:0]    color_o,
  output core_flags_t                  flags_o
);

  localparam int CW = COORD_BITS;
  localparam int TW = THICK_BITS;
  localparam int EW = COORD_BITS + 3;

  logic signed [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CW-1:0] tgt_x_q, tgt_y_q;
  logic        [CW-1:0] dx_q, dy_q;
  logic signed [EW-1:0] err_q, err_d;
  logic                 dxn_q, dyn_q;
  logic        [TW-1:0] half_q;
  logic signed [TW:0]   off_i_q, off_i_d, off_j_q, off_j_d;
  logic [COLOR_W-1:0]   color_q;
  logic                 busy_q, busy_d;

  logic signed [CW:0]   diff_x, diff_y;
  logic        [CW-1:0] abs_x, abs_y;
  logic        [TW-1:0] new_half;
  logic signed [TW:0]   half_s, neg_half;
  logic                 j_wrap, i_wrap, at_end, stamp_done;
  logic signed [EW:0]   e2, dx_e, dy_e, err_n;
  logic                 step_x, step_y;

  // Endpoint differences for a new line.
  assign diff_x = $signed({end_x_i[CW-1], end_x_i}) - $signed({start_x_i[CW-1], start_x_i});
  assign diff_y = $signed({end_y_i[CW-1], end_y_i}) - $signed({start_y_i[CW-1], start_y_i});
  assign abs_x  = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
  assign abs_y  = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
  assign new_half = thickness_i >> 1;

  assign half_s   = $signed({1'b0, half_q});
  assign neg_half = -half_s;

  assign px_o = $signed({{(PW-CW){cur_x_q[CW-1]}}, cur_x_q})
              + $signed({{(PW-TW-1){off_i_q[TW]}}, off_i_q});
  assign py_o = $signed({{(PW-CW){cur_y_q[CW-1]}}, cur_y_q})
              + $signed({{(PW-TW-1){off_j_q[TW]}}, off_j_q});

  assign j_wrap     = (off_j_q == half_s);
  assign i_wrap     = (off_i_q == half_s);
  assign at_end     = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign stamp_done = j_wrap && i_wrap;

  assign e2     = $signed({err_q, 1'b0});
  assign dx_e   = $signed({{(EW+1-CW){1'b0}}, dx_q});
  assign dy_e   = $signed({{(EW+1-CW){1'b0}}, dy_q});
  assign step_x = e2 > -dy_e;
  assign step_y = e2 < dx_e;
  assign err_n  = $signed({err_q[EW-1], err_q}) - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    err_d   = err_q;
    off_i_d = off_i_q;
    off_j_d = off_j_q;
    busy_d  = busy_q;
    if (j_wrap) begin
      off_j_d = neg_half;
      if (i_wrap) begin
        off_i_d = neg_half;
        if (at_end) begin
          busy_d = 1'b0;
        end else begin
          err_d = err_n[EW-1:0];
          if (step_x) begin
            cur_x_d = dxn_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
          end
          if (step_y) begin
            cur_y_d = dyn_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
          end
        end
      end else begin
        off_i_d = off_i_q + (TW+1)'(1);
      end
    end else begin
      off_j_d = off_j_q + (TW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept_i) begin
      if (op_i == OP_START) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        busy_q <= busy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (op_i == OP_START) begin
        cur_x_q <= start_x_i;
        cur_y_q <= start_y_i;
        tgt_x_q <= end_x_i;
        tgt_y_q <= end_y_i;
        dx_q    <= abs_x;
        dy_q    <= abs_y;
        dxn_q   <= diff_x[CW] || (diff_x == '0);
        dyn_q   <= diff_y[CW] || (diff_y == '0);
        err_q   <= $signed({{(EW-CW){1'b0}}, abs_x}) - $signed({{(EW-CW){1'b0}}, abs_y});
        half_q  <= new_half;
        off_i_q <= -$signed({1'b0, new_half});
        off_j_q <= -$signed({1'b0, new_half});
        color_q <= color_i;
      end else if (busy_q) begin
        cur_x_q <= cur_x_d;
        cur_y_q <= cur_y_d;
        err_q   <= err_d;
        off_i_q <= off_i_d;
        off_j_q <= off_j_d;
      end
    end
  end

  assign color_o       = color_q;
  assign flags_o.busy  = busy_q;
  assign flags_o.last  = stamp_done && at_end;

endmodule

@@ hw/rtl/tlr_pixel.sv @@
// Window clipping and framebuffer address of one brush pixel.
// Depends on tlr_pkg.
module tlr_pixel import tlr_pkg::*; #(
  parameter int PW = 18
) (
  input  logic signed [PW-1:0]      px_i,
  input  logic signed [PW-1:0]      py_i,
  input  logic        [CFG_W-1:0]   win_w_i,
  input  logic        [CFG_W-1:0]   win_h_i,
  input  logic        [COLOR_W-1:0] color_i,
  output logic                      we_o,
  output logic        [ADDR_W-1:0]  addr_o,
  output logic        [COLOR_W-1:0] color_o
);

  localparam int UW = (PW - 1 > CFG_W) ? PW - 1 : CFG_W;

  logic [UW-1:0]          px_u, py_u;
  logic                   in_win;
  logic [2*CFG_W-1:0]     row_base;
  logic [2*CFG_W-1:0]     lin_addr;

  assign px_u = UW'(px_i[PW-2:0]);
  assign py_u = UW'(py_i[PW-2:0]);

  assign in_win = !px_i[PW-1] && (px_u < UW'(win_w_i))
               && !py_i[PW-1] && (py_u < UW'(win_h_i));

  // Inside the window both coordinates fit the register width, so the low
  // bits are enough for the row base.
  assign row_base = py_u[CFG_W-1:0] * win_w_i;
  assign lin_addr = row_base + {{CFG_W{1'b0}}, px_u[CFG_W-1:0]};

  assign we_o    = in_win;
  assign addr_o  = in_win ? lin_addr[ADDR_W-1:0] : '0;
  assign color_o = in_win ? color_i : '0;

endmodule

@@ hw/rtl/thick_line_rasterizer_top.sv @@
// Top level of the thick line rasterizer: stream ports, window registers and
// the result register. Depends on tlr_pkg, tlr_core, tlr_pixel and the macro header.
//
// Usage: a beat on the slave stream with tuser = 0 starts a line from the
// endpoints, thickness and color in tdata; it answers with one beat that has
// active set and nothing else. Each following beat with tuser = 1 is a step
// and answers with exactly one brush pixel: x and y, and when the pixel lies
// inside the window also write enable (master tuser), the address
// y * window_width + x and the color. tlast marks the final pixel of the
// end point's stamp; that beat has active clear. A step while idle returns zeros.
// Each input beat yields its result beat in the next cycle in the single output
// register, so one beat is taken every cycle while the receiver is ready. When the
// receiver stalls, the result holds and beats are taken only in the cycle the
// result is drained. Reset empties the output, stops any line and sets the window
// to 640 by 480. The window registers are written through cfg_we_i, cfg_index_i
// and cfg_data_i by the user only while no line runs; the block does not enforce it.
`include "thick_line_rasterizer_top_macros.svh"

module thick_line_rasterizer_top import tlr_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int THICK_BITS = 8,
  localparam int IN_W  = ((4 * COORD_BITS + THICK_BITS + COLOR_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + ADDR_W + COLOR_W + 1 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // start_x, start_y, end_x, end_y, thickness, color, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic             s_axis_tuser_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // pixel_x, pixel_y, pixel_address, pixel_color, active, zero fill
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // write_enable
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CW = COORD_BITS;
  localparam int TW = THICK_BITS;
  localparam int PW = ((CW > TW) ? CW : TW) + 2;

  logic [CFG_W-1:0] win_w_q, win_h_q;

  logic             s_accept;
  logic             is_start, pix;
  logic signed [PW-1:0] px, py;
  logic [COLOR_W-1:0]   line_color, pix_color;
  core_flags_t          flags;
  logic                 pix_we;
  logic [ADDR_W-1:0]    pix_addr;

  logic                 out_valid_q;
  logic                 out_we_q, out_we_d;
  logic signed [CW-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [ADDR_W-1:0]    out_addr_q, out_addr_d;
  logic [COLOR_W-1:0]   out_color_q, out_color_d;
  logic                 out_last_q, out_last_d;
  logic                 out_active_q, out_active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q <= WIN_W_RESET;
      win_h_q <= WIN_H_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_WIDTH:  win_w_q <= cfg_data_i;
        REG_WINDOW_HEIGHT: win_h_q <= cfg_data_i;
      endcase
    end
  end

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  tlr_core #(
    .COORD_BITS (COORD_BITS),
    .THICK_BITS (THICK_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (s_accept),
    .op_i        (s_axis_tuser_i),
    .start_x_i   (s_axis_tdata_i[0 +: CW]),
    .start_y_i   (s_axis_tdata_i[CW +: CW]),
    .end_x_i     (s_axis_tdata_i[2*CW +: CW]),
    .end_y_i     (s_axis_tdata_i[3*CW +: CW]),
    .thickness_i (s_axis_tdata_i[4*CW +: TW]),
    .color_i     (s_axis_tdata_i[4*CW+TW +: COLOR_W]),
    .px_o        (px),
    .py_o        (py),
    .color_o     (line_color),
    .flags_o     (flags)
  );

  tlr_pixel #(
    .PW (PW)
  ) u_pixel (
    .px_i    (px),
    .py_i    (py),
    .win_w_i (win_w_q),
    .win_h_i (win_h_q),
    .color_i (line_color),
    .we_o    (pix_we),
    .addr_o  (pix_addr),
    .color_o (pix_color)
  );

  // A start beat answers with active only; a step while idle answers with zeros.
  assign is_start     = (s_axis_tuser_i == OP_START);
  assign pix          = !is_start && flags.busy;
  assign out_we_d     = pix && pix_we;
  assign out_x_d      = pix ? px[CW-1:0] : '0;
  assign out_y_d      = pix ? py[CW-1:0] : '0;
  assign out_addr_d   = pix ? pix_addr : '0;
  assign out_color_d  = pix ? pix_color : '0;
  assign out_last_d   = pix && flags.last;
  assign out_active_d = is_start || (pix && !flags.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      out_we_q     <= out_we_d;
      out_x_q      <= out_x_d;
      out_y_q      <= out_y_d;
      out_addr_q   <= out_addr_d;
      out_color_q  <= out_color_d;
      out_last_q   <= out_last_d;
      out_active_q <= out_active_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_we_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_W'({out_active_q, out_color_q, out_addr_q, out_y_q, out_x_q});

  `TLR_ASSERT(a_ready_when_empty, !out_valid_q |-> s_axis_tready_o, "input stalled while output register is empty")
  `TLR_ASSERT(a_last_ends_line, (out_valid_q && out_last_q) |-> !out_active_q, "line still active after its last pixel")
  `TLR_ASSERT(a_clipped_is_blank, (out_valid_q && !out_we_q) |-> (out_addr_q == '0 && out_color_q == '0), "suppressed pixel carries address or color")
  `TLR_ASSERT_NEXT(a_start_result, s_accept && is_start, out_valid_q && out_active_q && !out_we_q && !out_last_q, "start beat gave a wrong result")

endmodule
